### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TMS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true outside reset
`define TMS_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TMS_ASSERT(label, clk, rst_n, prop)
`define TMS_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hdl/tms_pkg.sv
// ---------------------------------------------------------------------------
// tms_pkg
// shared types and constants of the tone melody sequencer
// ---------------------------------------------------------------------------
package tms_pkg;

  // field widths
  localparam int CLK_W   = 29;
  localparam int PRESC_W = 17;
  localparam int LEN_W   = 9;
  localparam int FREQ_W  = 15;
  localparam int MS_W    = 16;
  localparam int SLOT_W  = 8;
  localparam int RLD_W   = 16;
  localparam int CNT_W   = 32;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // shared divider: widest dividend is clock * ms
  localparam int DIV_W     = CLK_W + MS_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // shared multiplier operand widths
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // tone constants
  localparam logic [RLD_W-1:0] REST_RELOAD = 16'd1000;
  localparam logic [MS_W-1:0]  GAP_MS      = 16'd30;
  localparam int               MS_PER_S    = 1000;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_PLAY  = 3'd1,
    OP_PAUSE = 3'd2,
    OP_STOP  = 3'd3,
    OP_TICK  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_CLK_HZ    = 2'd0,
    CFG_PRESCALER = 2'd1,
    CFG_SONG_LEN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [SLOT_W-1:0] note_slot;
    logic [FREQ_W-1:0] note_freq_hz;
    logic [MS_W-1:0]   note_time_ms;
  } in_item_t;

  typedef struct packed {
    logic              pwm_enabled;
    logic [RLD_W-1:0]  period_reload;
    logic [RLD_W-1:0]  duty_compare;
    logic [SLOT_W-1:0] current_note;
    logic              is_playing;
  } out_item_t;

  typedef struct packed {
    logic [CLK_W-1:0]   clk_hz;
    logic [PRESC_W-1:0] prescaler;
    logic [LEN_W-1:0]   song_len;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } note_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/tms_cfg_regs.sv
// ---------------------------------------------------------------------------
// tms_cfg_regs
// apb-style configuration registers: clock, prescaler, song length
// ---------------------------------------------------------------------------
module tms_cfg_regs import tms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode, unknown addresses ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        CFG_CLK_HZ:    cfg_d.clk_hz    = pwdata[CLK_W-1:0];
        CFG_PRESCALER: cfg_d.prescaler = pwdata[PRESC_W-1:0];
        CFG_SONG_LEN:  cfg_d.song_len  = pwdata[LEN_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_hz    <= 29'd72000000;
      cfg_q.prescaler <= 17'd72;
      cfg_q.song_len  <= 9'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      CFG_CLK_HZ:    prdata = CFG_DW'(cfg_q.clk_hz);
      CFG_PRESCALER: prdata = CFG_DW'(cfg_q.prescaler);
      CFG_SONG_LEN:  prdata = CFG_DW'(cfg_q.song_len);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/tms_note_mem.sv
// ---------------------------------------------------------------------------
// tms_note_mem
// note table, one write port and one registered read port
// ---------------------------------------------------------------------------
module tms_note_mem import tms_pkg::*; #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  note_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output note_t             rdata_o
);

  note_t mem_q [DEPTH];
  note_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tms_divider.sv
// ---------------------------------------------------------------------------
// tms_divider
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tms_divider import tms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  // one shift-subtract step
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hdl/tone_melody_sequencer_core.sv
// tone melody sequencer: note table, tick driven note sequencing and tone timing
// write, pause, stop, ignored ticks and ticks that start no tone: result registered in S_FINISH
// sounded tone: table read, then the 45-step shared divider runs for reload, then duration,
// with 4 multiply steps; a rest or a gap skips the reload run, and a gap skips the table read
// one item at a time; input stalls until the result is registered
// reset clears sequencing state and registers; the note table keeps its contents
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// tone_melody_sequencer_core
// top level: item sequencer, shared multiplier and divider, note table
// ---------------------------------------------------------------------------
module tone_melody_sequencer_core import tms_pkg::*; #(
  parameter int MAX_NOTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int TBL_DEPTH = (MAX_NOTES < 256) ? MAX_NOTES : 256;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int LEN_CAP   = TBL_DEPTH;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_MEM       = 11'b00000000010,
    S_TONE      = 11'b00000000100,
    S_RLD_START = 11'b00000001000,
    S_RLD_WAIT  = 11'b00000010000,
    S_MUL_N     = 11'b00000100000,
    S_MUL_PR    = 11'b00001000000,
    S_MUL_K     = 11'b00010000000,
    S_DUR_START = 11'b00100000000,
    S_DUR_WAIT  = 11'b01000000000,
    S_FINISH    = 11'b10000000000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] step_q, step_d;
  logic              playing_q, playing_d;
  logic              out_on_q, out_on_d;
  logic [RLD_W-1:0]  reload_q, reload_d;
  logic [RLD_W-1:0]  compare_q, compare_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic [DIV_W-1:0]  numer_q, numer_d;
  logic [MUL_PW-1:0] prod_q, prod_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  cfg_t              cfg;
  note_t             rd_note;
  note_t             wr_note;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              can_load;
  logic              mem_we;
  logic              mem_re;
  logic [PRESC_W-1:0] presc_eff;
  logic [LEN_W-1:0]  len_cap;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  step_next;
  logic [CNT_W-1:0]  count_inc;
  logic [RLD_W-1:0]  rl_eff;
  logic [RLD_W-1:0]  rld_sat;
  logic [RLD_W:0]    rld_plus;
  logic [CNT_W-1:0]  lim_sat;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;

  // configuration registers
  tms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // note table
  assign wr_note.freq = in_item_i.note_freq_hz;
  assign wr_note.ms   = in_item_i.note_time_ms;
  assign mem_we = accept && (in_item_i.opcode == OP_WRITE) &&
                  (32'(in_item_i.note_slot) < TBL_DEPTH);
  assign mem_re = (state_d == S_MEM);

  tms_note_mem #(
    .DEPTH  (TBL_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_item_i.note_slot[ADDR_W-1:0]),
    .wdata_i (wr_note),
    .re_i    (mem_re),
    .raddr_i (step_d[ADDR_W-1:0]),
    .rdata_o (rd_note)
  );

  // shared divider
  tms_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;

  // derived configuration values
  assign presc_eff = (cfg.prescaler == '0) ? PRESC_W'(1) : cfg.prescaler;
  assign len_cap   = (cfg.song_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : cfg.song_len;
  assign eff_len   = (len_cap == '0) ? LEN_W'(1) : len_cap;
  assign step_next = LEN_W'(step_q) + 1'b1;
  assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
  assign rl_eff    = (reload_q == '0) ? RLD_W'(1) : reload_q;

  // quotient saturation
  assign rld_sat  = (|div_rsp.quotient[DIV_W-1:RLD_W]) ? '1 : div_rsp.quotient[RLD_W-1:0];
  assign rld_plus = {1'b0, rld_sat} + 1'b1;
  assign lim_sat  = (|div_rsp.quotient[DIV_W-1:CNT_W]) ? '1 : div_rsp.quotient[CNT_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TONE: begin
        mul_a = MUL_AW'(presc_eff);
        mul_b = MUL_BW'(freq_q);
      end
      S_MUL_N: begin
        mul_a = MUL_AW'(cfg.clk_hz);
        mul_b = ms_q;
      end
      S_MUL_PR: begin
        mul_a = MUL_AW'(presc_eff);
        mul_b = rl_eff;
      end
      S_MUL_K: begin
        mul_a = prod_q[MUL_AW-1:0];
        mul_b = MUL_BW'(MS_PER_S);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  // divider requests: reload, then duration
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state_q == S_RLD_START) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'({cfg.clk_hz, 1'b0}) + DIV_W'(prod_q[31:0]);
      div_req.divisor  = DIV_W'({prod_q[31:0], 1'b0});
    end else if (state_q == S_DUR_START) begin
      div_req.start    = 1'b1;
      div_req.dividend = numer_q;
      div_req.divisor  = DIV_W'(prod_q[42:0]);
    end
  end

  // item sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    playing_d   = playing_q;
    out_on_d    = out_on_q;
    reload_d    = reload_q;
    compare_d   = compare_q;
    count_d     = count_q;
    limit_d     = limit_q;
    freq_d      = freq_q;
    ms_d        = ms_q;
    numer_d     = numer_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FINISH;
          unique case (in_item_i.opcode)
            OP_WRITE: state_d = S_FINISH;
            OP_PLAY: begin
              step_d    = '0;
              playing_d = 1'b1;
              state_d   = S_MEM;
            end
            OP_PAUSE: playing_d = 1'b0;
            OP_STOP: begin
              step_d    = '0;
              playing_d = 1'b0;
            end
            OP_TICK: begin
              if (out_on_q) begin
                count_d = count_inc;
                if (count_inc > limit_q) begin
                  if (!playing_q) begin
                    out_on_d = 1'b0;
                  end else if (step_next < eff_len) begin
                    if (compare_q == '0) begin
                      step_d  = step_next[SLOT_W-1:0];
                      state_d = S_MEM;
                    end else begin
                      freq_d  = '0;
                      ms_d    = GAP_MS;
                      state_d = S_TONE;
                    end
                  end else begin
                    playing_d = 1'b0;
                    out_on_d  = 1'b0;
                  end
                end
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      // table data arrives, slots beyond the table read as zero
      S_MEM: begin
        if (32'(step_q) < TBL_DEPTH) begin
          freq_d = rd_note.freq;
          ms_d   = rd_note.ms;
        end else begin
          freq_d = '0;
          ms_d   = '0;
        end
        state_d = S_TONE;
      end
      // rest tones take fixed timer values
      S_TONE: begin
        if (freq_q == '0) begin
          reload_d  = REST_RELOAD;
          compare_d = '0;
          state_d   = S_MUL_N;
        end else begin
          state_d = S_RLD_START;
        end
      end
      S_RLD_START: state_d = S_RLD_WAIT;
      S_RLD_WAIT: begin
        if (div_rsp.done) begin
          reload_d  = rld_sat;
          compare_d = rld_plus[RLD_W:1];
          state_d   = S_MUL_N;
        end
      end
      S_MUL_N: state_d = S_MUL_PR;
      S_MUL_PR: begin
        numer_d = prod_q[DIV_W-1:0];
        state_d = S_MUL_K;
      end
      S_MUL_K: state_d = S_DUR_START;
      S_DUR_START: state_d = S_DUR_WAIT;
      S_DUR_WAIT: begin
        if (div_rsp.done) begin
          limit_d  = lim_sat;
          count_d  = '0;
          out_on_d = 1'b1;
          state_d  = S_FINISH;
        end
      end
      // register the result once the output side has room
      S_FINISH: begin
        if (can_load) begin
          out_valid_d              = 1'b1;
          out_item_d.pwm_enabled   = out_on_q;
          out_item_d.period_reload = reload_q;
          out_item_d.duty_compare  = compare_q;
          out_item_d.current_note  = step_q;
          out_item_d.is_playing    = playing_q;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      playing_q   <= 1'b0;
      out_on_q    <= 1'b0;
      reload_q    <= '0;
      compare_q   <= '0;
      count_q     <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      playing_q   <= playing_d;
      out_on_q    <= out_on_d;
      reload_q    <= reload_d;
      compare_q   <= compare_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    ms_q       <= ms_d;
    numer_q    <= numer_d;
    prod_q     <= prod_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `TMS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q != S_IDLE))
  `TMS_ASSERT(a_finish_loads, clk_i, rst_ni,
              (state_q == S_FINISH && can_load) |=> (state_q == S_IDLE && out_valid_q))
  `TMS_NEVER(a_done_in_wait, clk_i, rst_ni,
             div_rsp.done && !(state_q == S_RLD_WAIT || state_q == S_DUR_WAIT))
  `TMS_NEVER(a_compare_needs_reload, clk_i, rst_ni, compare_q != '0 && reload_q == '0)

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the tone melody sequencer core against an in-bench melody tracker.
// Notes are written, played, paused and stopped while period ticks drive the
// sequencing; each accepted item yields one result that is compared field by
// field. The run walks through several timer setups, from the field extremes
// to random ones, with bursty input and a patterned output backpressure.
// ---------------------------------------------------------------------------
module testbench;
  import tms_pkg::*;

  localparam int NOTE_DEPTH = 256;

  // ---------------------------------------------------------------------------
  // melody tracker: mirrors the sequencer state and holds the results still due
  // ---------------------------------------------------------------------------
  class melody_tracker;
    logic [CLK_W-1:0]   clk_hz;
    logic [PRESC_W-1:0] presc;
    logic [LEN_W-1:0]   song_len;
    logic [FREQ_W-1:0]  freq_tab [NOTE_DEPTH];
    logic [MS_W-1:0]    ms_tab [NOTE_DEPTH];
    bit                 written [NOTE_DEPTH];
    logic [SLOT_W-1:0]  step;
    logic               playing;
    logic               output_on;
    logic [RLD_W-1:0]   reload;
    logic [RLD_W-1:0]   compare;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   limit;
    out_item_t          due_results [$];
    int unsigned        errors;

    function new();
      clk_hz    = 72000000;
      presc     = 72;
      song_len  = 1;
      step      = '0;
      playing   = 1'b0;
      output_on = 1'b0;
      reload    = '0;
      compare   = '0;
      count     = '0;
      limit     = '0;
      errors    = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_CLK_HZ:    clk_hz = val[CLK_W-1:0];
        CFG_PRESCALER: presc = val[PRESC_W-1:0];
        CFG_SONG_LEN:  song_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_length();
      int unsigned n;
      n = song_len;
      if (n > NOTE_DEPTH) n = NOTE_DEPTH;
      if (n == 0) n = 1;
      return n;
    endfunction

    // reload from the tone frequency, then the note length in periods
    function void sound_tone(logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
      longint unsigned p, d, r, rl, q, ck, dur;
      ck  = clk_hz;
      dur = ms;
      p   = (presc == 0) ? 1 : presc;
      if (freq != 0) begin
        d = p * freq;
        r = (ck * 2 + d) / (d * 2);
        if (r > 65535) r = 65535;
        reload  = r[RLD_W-1:0];
        compare = RLD_W'((r + 1) >> 1);
      end else begin
        reload  = REST_RELOAD;
        compare = '0;
      end
      rl = (reload == 0) ? 1 : reload;
      q  = (ck * dur) / (p * rl * MS_PER_S);
      limit = (q > 64'hFFFF_FFFF) ? '1 : q[CNT_W-1:0];
      count = '0;
      output_on = 1'b1;
    endfunction

    // one finished pwm period: expire the note, insert a gap or advance
    function void advance_on_tick();
      if (!output_on) return;
      if (count != '1) count++;
      if (count <= limit) return;
      if (!playing) begin
        output_on = 1'b0;
      end else if (step + 1 < eff_length()) begin
        if (compare == 0) begin
          step = step + 1'b1;
          sound_tone(freq_tab[step], ms_tab[step]);
        end else begin
          sound_tone('0, GAP_MS);
        end
      end else begin
        playing   = 1'b0;
        output_on = 1'b0;
      end
    endfunction

    function void note_accepted(in_item_t it);
      out_item_t res;
      case (it.opcode)
        OP_WRITE: begin
          freq_tab[it.note_slot] = it.note_freq_hz;
          ms_tab[it.note_slot]   = it.note_time_ms;
          written[it.note_slot]  = 1'b1;
        end
        OP_PLAY: begin
          step    = '0;
          playing = 1'b1;
          sound_tone(freq_tab[0], ms_tab[0]);
        end
        OP_PAUSE: playing = 1'b0;
        OP_STOP: begin
          step    = '0;
          playing = 1'b0;
        end
        OP_TICK: advance_on_tick();
        default: ;
      endcase
      res.pwm_enabled   = output_on;
      res.period_reload = reload;
      res.duty_compare  = compare;
      res.current_note  = step;
      res.is_playing    = playing;
      due_results.push_back(res);
    endfunction

    function string show(out_item_t r);
      return $sformatf("en=%0d reload=%0d compare=%0d note=%0d playing=%0d",
                       r.pwm_enabled, r.period_reload, r.duty_compare,
                       r.current_note, r.is_playing);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     diff;
      if (due_results.size() == 0) begin
        report($sformatf("result with none due: %s", show(got)));
        return;
      end
      want = due_results.pop_front();
      diff = "";
      if (got.pwm_enabled !== want.pwm_enabled) diff = {diff, " pwm_enabled"};
      if (got.period_reload !== want.period_reload) diff = {diff, " period_reload"};
      if (got.duty_compare !== want.duty_compare) diff = {diff, " duty_compare"};
      if (got.current_note !== want.current_note) diff = {diff, " current_note"};
      if (got.is_playing !== want.is_playing) diff = {diff, " is_playing"};
      if (diff != "")
        report($sformatf("field(s)%s: expected %s, got %s", diff, show(want), show(got)));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_item_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  melody_tracker tracker;
  int unsigned   burst_left = 0;
  int unsigned   stall_mode = 0;
  int unsigned   stall_left = 0;

  tone_melody_sequencer_core #(
    .MAX_NOTES(NOTE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output backpressure: one of four random modes, each held for a random run
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ~out_stall_i;
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_item_o);
  end

  // ---------------------------------------------------------------------------
  // item construction
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk(logic [2:0] op, int unsigned slot, int unsigned freq,
                                  int unsigned ms);
    in_item_t it;
    it.opcode       = op;
    it.note_slot    = SLOT_W'(slot);
    it.note_freq_hz = FREQ_W'(freq);
    it.note_time_ms = MS_W'(ms);
    return it;
  endfunction

  // mostly low tones and rests, sometimes the whole field
  function automatic int unsigned pick_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 65) return $urandom_range(1, 1000);
    if (r < 90) return $urandom_range(0, 20000);
    return $urandom_range(0, 32767);
  endfunction

  // mostly short notes so that melodies move on
  function automatic int unsigned pick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 12);
    if (r < 85) return $urandom_range(13, 200);
    if (r < 95) return $urandom_range(201, 2000);
    return $urandom_range(0, 65535);
  endfunction

  function automatic in_item_t random_item(logic [2:0] op);
    int unsigned slot;
    if (op == OP_WRITE && $urandom_range(0, 2) != 0)
      slot = $urandom_range(0, tracker.eff_length() - 1);
    else
      slot = $urandom_range(0, 255);
    return mk(op, slot, pick_freq(), pick_ms());
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one item; the sender pauses between bursts of random length
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_accepted(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
  endtask

  // register write followed by a read back
  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val)
      tracker.report($sformatf("register %s read %0d, written %0d", idx.name(), prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // fill every slot of the song that was never written
  task automatic fill_song();
    for (int s = 0; s < int'(tracker.eff_length()); s++) begin
      if (!tracker.written[s]) send_item(mk(OP_WRITE, s, pick_freq(), pick_ms()));
    end
  endtask

  // random play sessions; ignored items do not count
  task automatic play_sessions(input int unsigned quota);
    int unsigned counted;
    int unsigned r;
    logic [2:0]  op;
    counted = 0;
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      if (!tracker.output_on) begin
        if (r < 45) op = OP_PLAY;
        else if (r < 65) op = OP_WRITE;
        else if (r < 75) op = OP_TICK;
        else if (r < 83) op = OP_STOP;
        else if (r < 93) op = OP_PAUSE;
        else op = 3'($urandom_range(5, 7));
      end else begin
        if (r < 70) op = OP_TICK;
        else if (r < 80) op = OP_WRITE;
        else if (r < 86) op = OP_PLAY;
        else if (r < 92) op = OP_PAUSE;
        else if (r < 97) op = OP_STOP;
        else op = 3'($urandom_range(5, 7));
      end
      if (op <= OP_TICK && !(op == OP_TICK && !tracker.output_on)) counted++;
      send_item(random_item(op));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph_clk [7];
    int unsigned ph_presc [7];
    int unsigned ph_len [7];
    in_item_t    directed [$];
    int unsigned c, p, n;

    tracker    = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // fixed setups: slow and fast count clocks, zero prescaler, zero clock,
    // saturating reload, length extremes
    ph_clk   = '{1000000, 400000000, 400000000, 1000000, 20000, 536870911, 0};
    ph_presc = '{1000, 65536, 1, 65536, 0, 65536, 7};
    ph_len   = '{4, 256, 1, 0, 511, 12, 3};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset setup
    directed.push_back(mk(OP_TICK, 0, 0, 0));           // tick with output off
    directed.push_back(mk(OP_PAUSE, 0, 0, 0));
    directed.push_back(mk(OP_STOP, 255, 32767, 65535));
    directed.push_back(mk(3'd5, 255, 32767, 65535));    // unknown opcodes
    directed.push_back(mk(3'd6, 255, 32767, 65535));
    directed.push_back(mk(3'd7, 255, 32767, 65535));
    directed.push_back(mk(OP_WRITE, 255, 32767, 65535));
    directed.push_back(mk(OP_WRITE, 0, 0, 0));          // rest note
    directed.push_back(mk(OP_PLAY, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));           // last note expires
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_WRITE, 0, 1, 0));          // reload saturates
    directed.push_back(mk(OP_PLAY, 0, 0, 0));
    directed.push_back(mk(OP_PAUSE, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));           // paused note runs out
    directed.push_back(mk(OP_WRITE, 0, 20000, 1));
    directed.push_back(mk(OP_PLAY, 0, 0, 0));
    directed.push_back(mk(OP_STOP, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_PLAY, 0, 0, 0));           // restart while sounding
    foreach (directed[i]) send_item(directed[i]);

    // fixed setups, then random ones
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 7) begin
        c = ph_clk[ph];
        p = ph_presc[ph];
        n = ph_len[ph];
      end else begin
        c = $urandom_range(1000000, 400000000);
        p = c / $urandom_range(1000, 50000);
        if (p > 65536) p = 65536;
        if (p == 0) p = 1;
        n = $urandom_range(2, 40);
      end
      wait_idle();
      cfg_write(CFG_CLK_HZ, c);
      cfg_write(CFG_PRESCALER, p);
      cfg_write(CFG_SONG_LEN, n);
      fill_song();
      play_sessions(100);
    end

    // drain
    wait_idle();
    repeat (150) @(posedge clk_i);
    if (tracker.due_results.size() != 0)
      tracker.report($sformatf("%0d result(s) never arrived", tracker.due_results.size()));
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
